// ===== rtl/qvr_pkg.sv =====
// Shared types and constants for the quaternion vector rotation pipeline.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package qvr_pkg;

   localparam int QUAT_WIDTH = 16;
   localparam int VEC_WIDTH  = 16;

   // Fraction bits of quaternion products and matrix elements (2*(QUAT_WIDTH-1)).
   localparam int MAT_FRAC   = 2 * (QUAT_WIDTH - 1);

   localparam int PROD_WIDTH = 2 * QUAT_WIDTH;          // q_a * q_b, exact
   localparam int ELEM_WIDTH = PROD_WIDTH + 2;          // 2*(p +/- r), 2*(half - a - b)
   localparam int TERM_WIDTH = ELEM_WIDTH + VEC_WIDTH;  // element * vector component
   localparam int SUM_WIDTH  = TERM_WIDTH + 2;          // three terms plus rounding half
   localparam int QUO_WIDTH  = SUM_WIDTH - MAT_FRAC;    // integer part of the sum

   localparam logic signed [ELEM_WIDTH-1:0] ELEM_HALF = ELEM_WIDTH'(1) << (MAT_FRAC - 1);
   localparam logic signed [SUM_WIDTH-1:0]  SUM_HALF  = SUM_WIDTH'(1) << (MAT_FRAC - 1);

   localparam logic signed [QUO_WIDTH-1:0] OUT_MAX = QUO_WIDTH'((1 << (VEC_WIDTH - 1)) - 1);
   localparam logic signed [QUO_WIDTH-1:0] OUT_MIN = -OUT_MAX - QUO_WIDTH'(1);

   // Direction opcodes
   localparam logic DIR_BODY_TO_EARTH = 1'b0;
   localparam logic DIR_EARTH_TO_BODY = 1'b1;

   typedef logic signed [ELEM_WIDTH-1:0] elem_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;
   typedef logic signed [VEC_WIDTH-1:0]  vec_comp_type;

   typedef logic [2:0][ELEM_WIDTH-1:0] elem_row_type;
   typedef logic [2:0][VEC_WIDTH-1:0]  vec_row_type;

   typedef struct packed {
      logic                          direction;
      logic signed [QUAT_WIDTH-1:0]  quat_w;
      logic signed [QUAT_WIDTH-1:0]  quat_x;
      logic signed [QUAT_WIDTH-1:0]  quat_y;
      logic signed [QUAT_WIDTH-1:0]  quat_z;
      logic signed [VEC_WIDTH-1:0]   vec_x;
      logic signed [VEC_WIDTH-1:0]   vec_y;
      logic signed [VEC_WIDTH-1:0]   vec_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [VEC_WIDTH-1:0]   out_x;
      logic signed [VEC_WIDTH-1:0]   out_y;
      logic signed [VEC_WIDTH-1:0]   out_z;
      logic                          saturated;
   } rsp_payload_type;

   // Load enables for the three stages inside each row unit
   typedef struct packed {
      logic term_load;
      logic sum_load;
      logic out_load;
   } row_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/qvr_row.sv =====
// One output component: element*vector products, sum with rounding, shift and clip.
// Depends on qvr_pkg; loads are driven by the pipeline control in the top level.
`default_nettype none

module qvr_row (
   input  wire logic                  clock,
   input  wire qvr_pkg::row_ctrl_type ctrl,
   input  wire qvr_pkg::elem_row_type elem,
   input  wire qvr_pkg::vec_row_type  vec,
   output logic signed [qvr_pkg::VEC_WIDTH-1:0] out_value,
   output logic                                 out_sat
);

   logic signed [qvr_pkg::TERM_WIDTH-1:0] term_ff [3];
   logic signed [qvr_pkg::TERM_WIDTH-1:0] term_in [3];
   logic signed [qvr_pkg::SUM_WIDTH-1:0]  sum_ff;
   logic signed [qvr_pkg::SUM_WIDTH-1:0]  sum_in;
   logic signed [qvr_pkg::QUO_WIDTH-1:0]  quo;
   logic signed [qvr_pkg::VEC_WIDTH-1:0]  out_ff;
   logic signed [qvr_pkg::VEC_WIDTH-1:0]  out_in;
   logic                                  sat_ff;
   logic                                  sat_in;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         term_in[c] = qvr_pkg::TERM_WIDTH'($signed(elem[c])) *
                      qvr_pkg::TERM_WIDTH'($signed(vec[c]));
      end
   end

   // Fold the rounding half in with the sum so the final stage is a plain floor shift
   assign sum_in = qvr_pkg::SUM_WIDTH'(term_ff[0]) + qvr_pkg::SUM_WIDTH'(term_ff[1]) +
                   qvr_pkg::SUM_WIDTH'(term_ff[2]) + qvr_pkg::SUM_HALF;

   assign quo = sum_ff[qvr_pkg::SUM_WIDTH-1:qvr_pkg::MAT_FRAC];

   always_comb begin
      if (quo > qvr_pkg::OUT_MAX) begin
         out_in = qvr_pkg::VEC_WIDTH'(qvr_pkg::OUT_MAX);
         sat_in = 1'b1;
      end else if (quo < qvr_pkg::OUT_MIN) begin
         out_in = qvr_pkg::VEC_WIDTH'(qvr_pkg::OUT_MIN);
         sat_in = 1'b1;
      end else begin
         out_in = quo[qvr_pkg::VEC_WIDTH-1:0];
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.term_load) begin
         term_ff <= term_in;
      end
      if (ctrl.sum_load) begin
         sum_ff <= sum_in;
      end
      if (ctrl.out_load) begin
         out_ff <= out_in;
         sat_ff <= sat_in;
      end
   end

   assign out_value = out_ff;
   assign out_sat   = sat_ff;

endmodule

`default_nettype wire

// ===== rtl/quaternion_vector_rotate.sv =====
// Top level of the quaternion vector rotation pipeline: handshakes, products, matrix.
// Depends on qvr_pkg and instantiates qvr_row once per output component.
`default_nettype none

// Channel   Ports                                    Direction  Moves
// --------  ---------------------------------------  ---------  --------------------------------
// request   req_valid, req_ready, req_payload        in         quaternion, vector, direction
// response  rsp_valid, rsp_ready, rsp_payload        out        rotated vector, saturated flag
//
// Five register stages: quaternion products, matrix elements (transposed for earth to body),
// element*vector products, row sums, then round and clip into the output register.
// rsp_valid rises once an accepted request has reached the output register of stage 5;
// one request is taken every cycle while the response side does not stall.
// Each stage holds only while it is full and the stage after it cannot take its contents,
// so a stall on the response side closes bubbles first and loses or repeats nothing.
// Reset clears the stage valid bits only; payload registers carry no reset.

module quaternion_vector_rotate (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire qvr_pkg::req_payload_type req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output qvr_pkg::rsp_payload_type      rsp_payload
);

   // Stage valid bits and the ready chain that runs back from the response port
   logic [5:1] valid_ff;
   logic [5:1] valid_in;
   logic [6:1] stage_ready;

   always_comb begin
      stage_ready[6] = rsp_ready;
      for (int s = 5; s >= 1; s--) begin
         stage_ready[s] = !valid_ff[s] || stage_ready[s+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (stage_ready[1]) valid_in[1] = req_valid;
      for (int s = 2; s <= 5; s++) begin
         if (stage_ready[s]) valid_in[s] = valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = stage_ready[1];
   assign rsp_valid = valid_ff[5];

   // Stage 1: the nine quaternion products, exact with MAT_FRAC fraction bits
   qvr_pkg::prod_type xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   qvr_pkg::vec_row_type vec_s1_ff;
   logic                 dir_s1_ff;

   always_ff @(posedge clock) begin
      if (stage_ready[1]) begin
         xx_ff     <= qvr_pkg::PROD_WIDTH'(req_payload.quat_x) *
                      qvr_pkg::PROD_WIDTH'(req_payload.quat_x);
         yy_ff     <= qvr_pkg::PROD_WIDTH'(req_payload.quat_y) *
                      qvr_pkg::PROD_WIDTH'(req_payload.quat_y);
         zz_ff     <= qvr_pkg::PROD_WIDTH'(req_payload.quat_z) *
                      qvr_pkg::PROD_WIDTH'(req_payload.quat_z);
         xy_ff     <= qvr_pkg::PROD_WIDTH'(req_payload.quat_x) *
                      qvr_pkg::PROD_WIDTH'(req_payload.quat_y);
         xz_ff     <= qvr_pkg::PROD_WIDTH'(req_payload.quat_x) *
                      qvr_pkg::PROD_WIDTH'(req_payload.quat_z);
         yz_ff     <= qvr_pkg::PROD_WIDTH'(req_payload.quat_y) *
                      qvr_pkg::PROD_WIDTH'(req_payload.quat_z);
         wx_ff     <= qvr_pkg::PROD_WIDTH'(req_payload.quat_w) *
                      qvr_pkg::PROD_WIDTH'(req_payload.quat_x);
         wy_ff     <= qvr_pkg::PROD_WIDTH'(req_payload.quat_w) *
                      qvr_pkg::PROD_WIDTH'(req_payload.quat_y);
         wz_ff     <= qvr_pkg::PROD_WIDTH'(req_payload.quat_w) *
                      qvr_pkg::PROD_WIDTH'(req_payload.quat_z);
         vec_s1_ff <= {req_payload.vec_z, req_payload.vec_y, req_payload.vec_x};
         dir_s1_ff <= req_payload.direction;
      end
   end

   // Stage 2: matrix elements, already arranged as the rows to be used
   qvr_pkg::elem_type m [3][3];
   qvr_pkg::elem_row_type elem_in [3];
   qvr_pkg::elem_row_type elem_ff [3];
   qvr_pkg::vec_row_type  vec_s2_ff;

   function automatic qvr_pkg::elem_type ext(input qvr_pkg::prod_type p);
      return qvr_pkg::ELEM_WIDTH'(p);
   endfunction

   always_comb begin
      m[0][0] = (qvr_pkg::ELEM_HALF - ext(yy_ff) - ext(zz_ff)) <<< 1;
      m[0][1] = (ext(xy_ff) - ext(wz_ff)) <<< 1;
      m[0][2] = (ext(xz_ff) + ext(wy_ff)) <<< 1;
      m[1][0] = (ext(xy_ff) + ext(wz_ff)) <<< 1;
      m[1][1] = (qvr_pkg::ELEM_HALF - ext(xx_ff) - ext(zz_ff)) <<< 1;
      m[1][2] = (ext(yz_ff) - ext(wx_ff)) <<< 1;
      m[2][0] = (ext(xz_ff) - ext(wy_ff)) <<< 1;
      m[2][1] = (ext(yz_ff) + ext(wx_ff)) <<< 1;
      m[2][2] = (qvr_pkg::ELEM_HALF - ext(xx_ff) - ext(yy_ff)) <<< 1;
   end

   // Earth to body uses the transpose: swap row and column on selection
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (dir_s1_ff == qvr_pkg::DIR_EARTH_TO_BODY) begin
               elem_in[r][c] = m[c][r];
            end else begin
               elem_in[r][c] = m[r][c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[2]) begin
         elem_ff   <= elem_in;
         vec_s2_ff <= vec_s1_ff;
      end
   end

   // Stages 3 to 5 live in the row units
   qvr_pkg::row_ctrl_type row_ctrl;

   assign row_ctrl.term_load = stage_ready[3];
   assign row_ctrl.sum_load  = stage_ready[4];
   assign row_ctrl.out_load  = stage_ready[5];

   logic signed [qvr_pkg::VEC_WIDTH-1:0] row_value [3];
   logic [2:0]                           row_sat;

   for (genvar r = 0; r < 3; r++) begin : g_row
      qvr_row u_row (
         .clock     (clock),
         .ctrl      (row_ctrl),
         .elem      (elem_ff[r]),
         .vec       (vec_s2_ff),
         .out_value (row_value[r]),
         .out_sat   (row_sat[r])
      );
   end

   assign rsp_payload.out_x     = row_value[0];
   assign rsp_payload.out_y     = row_value[1];
   assign rsp_payload.out_z     = row_value[2];
   assign rsp_payload.saturated = |row_sat;

endmodule

`default_nettype wire

// ===== test/quaternion_vector_rotate_test.sv =====
// Self-checking testbench for quaternion_vector_rotate: directed and random requests,
// each result checked against an in-bench fixed-point rotation predictor.
// Depends on qvr_pkg and the RTL top level only.
`timescale 1ns / 1ps

module quaternion_vector_rotate_test;

   import qvr_pkg::*;

   localparam int RESET_CYCLES = 11;
   localparam int DRAIN_CYCLES = 20;     // pipeline is five deep; allow plenty more
   localparam int CYCLE_LIMIT  = 200000; // slowest legal run stays well under this limit
   localparam int ELEM_FRAC    = 30;     // fraction bits of matrix elements
   localparam int PRINT_LIMIT  = 100;

   localparam longint ROUND_HALF = longint'(1) <<< (ELEM_FRAC - 1);

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;

   // Rotated vectors still owed by the block, oldest first
   rsp_payload_type expected_rotations[$];

   int error_count;
   int cycle_count;
   bit idle_enabled;

   quaternion_vector_rotate i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // ------------------------------------------------------------------------
   // Predictor: build the rotation matrix from the quaternion products with
   // 30 fraction bits, take R or its transpose, then round each dot product
   // half up and clip it to the vector width.
   // ------------------------------------------------------------------------
   function automatic rsp_payload_type predict_rotation(input req_payload_type p);
      longint w, x, y, z;
      longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
      longint v[3];
      longint m[3][3];
      longint row[3];
      longint sum;
      longint lim_hi, lim_lo;
      logic [VEC_WIDTH-1:0] comp[3];
      bit clipped;
      rsp_payload_type r;
      w = $signed(p.quat_w);
      x = $signed(p.quat_x);
      y = $signed(p.quat_y);
      z = $signed(p.quat_z);
      v[0] = $signed(p.vec_x);
      v[1] = $signed(p.vec_y);
      v[2] = $signed(p.vec_z);
      // Q1.15 times Q1.15 already carries exactly 30 fraction bits
      xx = x * x;  yy = y * y;  zz = z * z;
      xy = x * y;  xz = x * z;  yz = y * z;
      wx = w * x;  wy = w * y;  wz = w * z;
      m[0][0] = 2 * (ROUND_HALF - yy - zz);
      m[0][1] = 2 * (xy - wz);
      m[0][2] = 2 * (xz + wy);
      m[1][0] = 2 * (xy + wz);
      m[1][1] = 2 * (ROUND_HALF - xx - zz);
      m[1][2] = 2 * (yz - wx);
      m[2][0] = 2 * (xz - wy);
      m[2][1] = 2 * (yz + wx);
      m[2][2] = 2 * (ROUND_HALF - xx - yy);
      lim_hi = (longint'(1) <<< (VEC_WIDTH - 1)) - 1;
      lim_lo = -lim_hi - 1;
      clipped = 1'b0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            row[j] = (p.direction == DIR_EARTH_TO_BODY) ? m[j][i] : m[i][j];
         end
         // At most about 2^50 in magnitude, so 64 bits hold it exactly
         sum = row[0] * v[0] + row[1] * v[1] + row[2] * v[2] + ROUND_HALF;
         sum = sum >>> ELEM_FRAC;
         if (sum > lim_hi) begin
            sum = lim_hi;
            clipped = 1'b1;
         end
         if (sum < lim_lo) begin
            sum = lim_lo;
            clipped = 1'b1;
         end
         comp[i] = sum[VEC_WIDTH-1:0];
      end
      r.out_x     = comp[0];
      r.out_y     = comp[1];
      r.out_z     = comp[2];
      r.saturated = clipped;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint want, input longint got);
      if (error_count < PRINT_LIMIT) begin
         $display("ERROR cycle %0d: %s expected %0d got %0d", cycle_count, what, want, got);
      end
      error_count++;
   endtask

   // ------------------------------------------------------------------------
   // Request and response monitors. Both sample at the rising edge; the bench
   // only changes inputs on the falling edge, so nothing here races the DUT.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_responses
      rsp_payload_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_rotations.push_back(predict_rotation(req_payload));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rotations.size() == 0) begin
               report_mismatch("response with no request outstanding, out_x", 0,
                               $signed(rsp_payload.out_x));
            end else begin
               want = expected_rotations.pop_front();
               if (rsp_payload.out_x !== want.out_x)
                  report_mismatch("out_x", $signed(want.out_x), $signed(rsp_payload.out_x));
               if (rsp_payload.out_y !== want.out_y)
                  report_mismatch("out_y", $signed(want.out_y), $signed(rsp_payload.out_y));
               if (rsp_payload.out_z !== want.out_z)
                  report_mismatch("out_z", $signed(want.out_z), $signed(rsp_payload.out_z));
               if (rsp_payload.saturated !== want.saturated)
                  report_mismatch("saturated", want.saturated, rsp_payload.saturated);
            end
         end
      end
   end

   // Response side: mix runs of ready with stall bursts, picked at random.
   // With idling switched off, hold ready high.
   initial begin : drive_rsp_ready
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (idle_enabled && $urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 5)) begin
               @(negedge clock);
               rsp_ready = 1'b0;
            end
         end else begin
            repeat ($urandom_range(1, 8)) begin
               @(negedge clock);
               rsp_ready = 1'b1;
            end
         end
      end
   end

   // Watchdog: stop the run if it goes far beyond the slowest legal length
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Request driver. Valid is raised on a falling edge and held, payload
   // unchanged, until the rising edge that accepts it. The next call either
   // replaces the payload straight away or drops valid for an idle burst.
   // ------------------------------------------------------------------------
   task automatic send_request(input req_payload_type p);
      int gap;
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         repeat (gap) begin
            @(negedge clock);
            req_valid = 1'b0;
         end
      end
      @(negedge clock);
      req_valid   = 1'b1;
      req_payload = p;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic req_payload_type make_request(input logic dir,
                                                    input int w, input int x,
                                                    input int y, input int z,
                                                    input int vx, input int vy,
                                                    input int vz);
      req_payload_type p;
      p.direction = dir;
      p.quat_w    = QUAT_WIDTH'(w);
      p.quat_x    = QUAT_WIDTH'(x);
      p.quat_y    = QUAT_WIDTH'(y);
      p.quat_z    = QUAT_WIDTH'(z);
      p.vec_x     = VEC_WIDTH'(vx);
      p.vec_y     = VEC_WIDTH'(vy);
      p.vec_z     = VEC_WIDTH'(vz);
      return p;
   endfunction

   // Mostly full-range codes, with the corners of the range mixed in
   function automatic logic signed [QUAT_WIDTH-1:0] random_quat_code();
      if ($urandom_range(0, 3) != 0) return QUAT_WIDTH'($urandom);
      case ($urandom_range(0, 4))
         0:       return {1'b0, {(QUAT_WIDTH-1){1'b1}}};
         1:       return {1'b1, {(QUAT_WIDTH-1){1'b0}}};
         2:       return '0;
         3:       return QUAT_WIDTH'(1);
         default: return '1;
      endcase
   endfunction

   function automatic logic signed [VEC_WIDTH-1:0] random_vec_code();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 4))
               0:       return {1'b0, {(VEC_WIDTH-1){1'b1}}};
               1:       return {1'b1, {(VEC_WIDTH-1){1'b0}}};
               2:       return '0;
               3:       return VEC_WIDTH'(1);
               default: return '1;
            endcase
         end
         1:       return VEC_WIDTH'(int'($urandom_range(0, 200)) - 100);
         default: return VEC_WIDTH'($urandom);
      endcase
   endfunction

   // A unit quaternion keeps the rotation well-formed and the outputs mostly in
   // range; a raw one exercises scaling and saturation.
   function automatic req_payload_type build_random_request(input bit unit_quat);
      req_payload_type p;
      real a[4];
      real norm;
      p.direction = $urandom_range(0, 1) ? DIR_EARTH_TO_BODY : DIR_BODY_TO_EARTH;
      if (unit_quat) begin
         norm = 0.0;
         for (int i = 0; i < 4; i++) begin
            a[i] = (real'(int'($urandom_range(0, 65535))) - 32768.0) / 32768.0;
            norm += a[i] * a[i];
         end
         norm = $sqrt(norm);
         if (norm < 0.01) begin
            a[0] = 1.0;
            a[1] = 0.0;
            a[2] = 0.0;
            a[3] = 0.0;
            norm = 1.0;
         end
         p.quat_w = QUAT_WIDTH'($rtoi(a[0] / norm * 32767.0));
         p.quat_x = QUAT_WIDTH'($rtoi(a[1] / norm * 32767.0));
         p.quat_y = QUAT_WIDTH'($rtoi(a[2] / norm * 32767.0));
         p.quat_z = QUAT_WIDTH'($rtoi(a[3] / norm * 32767.0));
      end else begin
         p.quat_w = random_quat_code();
         p.quat_x = random_quat_code();
         p.quat_y = random_quat_code();
         p.quat_z = random_quat_code();
      end
      p.vec_x = random_vec_code();
      p.vec_y = random_vec_code();
      p.vec_z = random_vec_code();
      return p;
   endfunction

   // ------------------------------------------------------------------------
   // Test tasks
   // ------------------------------------------------------------------------

   // Identity rotations with vector extremes, the most negative scalar code taken
   // as -1.0, and the all-zero quaternion, whose matrix is also the identity.
   task automatic test_identity_and_extremes();
      send_request(make_request(DIR_BODY_TO_EARTH, 32767, 0, 0, 0, 32767, -32768, 1));
      send_request(make_request(DIR_EARTH_TO_BODY, 32767, 0, 0, 0, 32767, -32768, 1));
      send_request(make_request(DIR_BODY_TO_EARTH, 32767, 0, 0, 0, 0, 0, 0));
      send_request(make_request(DIR_BODY_TO_EARTH, -32768, 0, 0, 0, 32767, -32768, -12345));
      send_request(make_request(DIR_EARTH_TO_BODY, 0, 0, 0, 0, -32768, 32767, 7));
   endtask

   // Quarter turns about each axis in both directions, then a half turn about x
   // that keeps the most negative vector code, which sits on the x axis.
   task automatic test_quarter_and_half_turns();
      send_request(make_request(DIR_BODY_TO_EARTH, 23170, 23170, 0, 0, 1000, 2000, 3000));
      send_request(make_request(DIR_EARTH_TO_BODY, 23170, 23170, 0, 0, 1000, 2000, 3000));
      send_request(make_request(DIR_BODY_TO_EARTH, 23170, 0, 23170, 0, 1000, 2000, 3000));
      send_request(make_request(DIR_EARTH_TO_BODY, 23170, 0, 23170, 0, 1000, 2000, 3000));
      send_request(make_request(DIR_BODY_TO_EARTH, 23170, 0, 0, 23170, 1000, 2000, 3000));
      send_request(make_request(DIR_EARTH_TO_BODY, 23170, 0, 0, 23170, 1000, 2000, 3000));
      send_request(make_request(DIR_BODY_TO_EARTH, 0, 32767, 0, 0, -32768, 32767, 100));
      send_request(make_request(DIR_EARTH_TO_BODY, 0, 32767, 0, 0, -32768, 32767, 100));
   endtask

   // z = 0.5 makes m[0][0] and m[1][1] exactly one half, so +1 and -1 land on
   // a tie; ties go up. The all-halves quaternion permutes the axes exactly.
   task automatic test_half_up_rounding();
      send_request(make_request(DIR_BODY_TO_EARTH, 0, 0, 0, 16384, 1, -1, 3));
      send_request(make_request(DIR_EARTH_TO_BODY, 0, 0, 0, 16384, -1, 1, -3));
      send_request(make_request(DIR_BODY_TO_EARTH, 16384, 16384, 16384, 16384,
                                32767, -32768, 5));
   endtask

   // Non-unit quaternions scale the vector far out of range
   task automatic test_saturation();
      send_request(make_request(DIR_BODY_TO_EARTH, -32768, -32768, -32768, -32768,
                                32767, 32767, 32767));
      send_request(make_request(DIR_EARTH_TO_BODY, -32768, -32768, -32768, -32768,
                                32767, 32767, 32767));
      send_request(make_request(DIR_BODY_TO_EARTH, 32767, 32767, 32767, 32767,
                                -32768, -32768, -32768));
      send_request(make_request(DIR_EARTH_TO_BODY, 0, -32768, -32768, 0,
                                32767, -32768, 32767));
   endtask

   task automatic test_random_unit_quaternions(input int count);
      repeat (count) send_request(build_random_request(1'b1));
   endtask

   task automatic test_random_raw_quaternions(input int count);
      repeat (count) send_request(build_random_request(1'b0));
   endtask

   // Full rate: no idling on either side, unit and raw quaternions mixed
   task automatic test_back_to_back(input int count);
      idle_enabled = 1'b0;
      repeat (count) send_request(build_random_request($urandom_range(0, 1)));
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      error_count  = 0;
      idle_enabled = 1'b1;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      // Hold reset over a fixed number of rising edges, release it on a falling edge
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_identity_and_extremes();
      test_quarter_and_half_turns();
      test_half_up_rounding();
      test_saturation();
      test_random_unit_quaternions(450);
      test_random_raw_quaternions(350);
      test_back_to_back(150);

      // Drop valid so the last request is not taken twice, then drain
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_rotations.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
